>>> rtl/core/assert_macros.svh
// Assertion macros used by the deframer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/core/lprd_pkg.sv
// Package for the length-prefixed response deframer: codes and result type
`default_nettype none
package lprd_pkg;

	localparam int unsigned POS_W = 17;

	// result kinds
	localparam logic [2:0] KIND_ERROR = 3'd0;
	localparam logic [2:0] KIND_OK    = 3'd1;
	localparam logic [2:0] KIND_VALUE = 3'd2;
	localparam logic [2:0] KIND_PONG  = 3'd3;
	localparam logic [2:0] KIND_INFO  = 3'd4;
	localparam logic [2:0] KIND_KEYS  = 3'd5;

	// result status codes
	localparam logic [2:0] ST_GOOD     = 3'd0;
	localparam logic [2:0] ST_UNKNOWN  = 3'd1;
	localparam logic [2:0] ST_SHORT    = 3'd2;
	localparam logic [2:0] ST_MISMATCH = 3'd3;
	localparam logic [2:0] ST_LARGE    = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_FAILURE = 3'd0;
	localparam logic [2:0] REG_SUCCESS = 3'd1;
	localparam logic [2:0] REG_PING    = 3'd2;
	localparam logic [2:0] REG_INFO    = 3'd3;
	localparam logic [2:0] REG_KEYS    = 3'd4;
	localparam logic [2:0] REG_MAXLEN  = 3'd5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  status;
		logic [15:0] frame_len;
		logic [15:0] pay_len;
		logic [31:0] seen;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/core/length_prefixed_response_deframer.sv
// Top level of the length-prefixed response deframer
`default_nettype none
`include "assert_macros.svh"

// Takes one received byte per cycle on in_valid/in_ready and tracks the
// frame with a 17-bit byte position counter, the header length, the type
// byte and the declared payload length. Each byte is handled by compares
// and adds against those registers, so the block sustains one byte per
// clock while in_ready is high. A result is registered when the byte that
// ends a frame (or the second header byte of an oversized frame) is
// accepted. A two-entry output (register plus skid stage) keeps bytes
// flowing while a result waits; in_ready drops only when both entries hold
// results. Configuration writes take effect at once and are meant to be
// done while the stream is idle.
module length_prefixed_response_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [16:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       frame_kind,
	output logic [2:0]       frame_status,
	output logic [15:0]      core_length,
	output logic [15:0]      payload_length,
	output logic [31:0]      frames_seen
);
	import lprd_pkg::*;

	logic [7:0]       fail_code_q, succ_code_q, ping_code_q, info_code_q, keys_code_q;
	logic [16:0]      max_bytes_q;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      hdr_q, hdr_d, hdr_new;
	logic [7:0]       typ_q, typ_d;
	logic [15:0]      dp_q, dp_d;
	logic [31:0]      frame_cnt_q;

	logic             emit;
	res_t             res_new;
	res_t             out_q, skid_q;
	logic             out_valid_q, skid_valid_q;
	logic             accept, push, pop;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;
	assign push     = accept && emit;
	assign pop      = out_valid_q && out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_code_q <= 8'd0;
			succ_code_q <= 8'd1;
			ping_code_q <= 8'd2;
			info_code_q <= 8'd3;
			keys_code_q <= 8'd4;
			max_bytes_q <= 17'd4096;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FAILURE: fail_code_q <= cfg_data[7:0];
				REG_SUCCESS: succ_code_q <= cfg_data[7:0];
				REG_PING:    ping_code_q <= cfg_data[7:0];
				REG_INFO:    info_code_q <= cfg_data[7:0];
				REG_KEYS:    keys_code_q <= cfg_data[7:0];
				REG_MAXLEN:  max_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-byte frame tracking
	always_comb begin
		pos_d             = pos_q;
		hdr_d             = hdr_q;
		typ_d             = typ_q;
		dp_d              = dp_q;
		emit              = 1'b0;
		hdr_new           = {hdr_q[15:8], rx_byte};
		res_new.kind      = KIND_ERROR;
		res_new.status    = ST_GOOD;
		res_new.frame_len = hdr_q;
		res_new.pay_len   = 16'd0;
		res_new.seen      = frame_cnt_q + 32'd1;

		priority if (pos_q == 17'd0) begin
			hdr_d = {rx_byte, 8'h00};
			typ_d = 8'd0;
			dp_d  = 16'd0;
			pos_d = 17'd1;
		end else if (pos_q == 17'd1) begin
			hdr_d             = hdr_new;
			res_new.frame_len = hdr_new;
			priority if (({1'b0, hdr_new} + 17'd2) > max_bytes_q) begin
				emit           = 1'b1;
				res_new.status = ST_LARGE;
			end else if (hdr_new == 16'd0) begin
				emit           = 1'b1;
				res_new.status = ST_SHORT;
			end else begin
				pos_d = 17'd2;
			end
		end else if (pos_q == 17'd2) begin
			typ_d = rx_byte;
			if (hdr_q == 16'd1) begin
				emit = 1'b1;
				priority if (rx_byte == fail_code_q) begin
					res_new.kind = KIND_ERROR;
				end else if (rx_byte == succ_code_q) begin
					res_new.kind = KIND_OK;
				end else begin
					res_new.status = ST_UNKNOWN;
				end
			end else begin
				pos_d = 17'd3;
			end
		end else begin
			if (pos_q == 17'd3) begin
				dp_d = {rx_byte, 8'h00};
			end else if (pos_q == 17'd4) begin
				dp_d = {dp_q[15:8], rx_byte};
			end
			if (pos_q >= ({1'b0, hdr_q} + 17'd1)) begin
				emit = 1'b1;
				priority if (typ_q == succ_code_q) begin
					res_new.kind = KIND_VALUE;
				end else if (typ_q == ping_code_q) begin
					res_new.kind = KIND_PONG;
				end else if (typ_q == info_code_q) begin
					res_new.kind = KIND_INFO;
				end else if (typ_q == keys_code_q) begin
					res_new.kind = KIND_KEYS;
				end else begin
					res_new.status = ST_UNKNOWN;
				end
				if (res_new.status != ST_UNKNOWN) begin
					priority if (hdr_q < 16'd3) begin
						res_new.status = ST_SHORT;
					end else if (dp_d != (hdr_q - 16'd3)) begin
						res_new.status  = ST_MISMATCH;
						res_new.pay_len = dp_d;
					end else begin
						res_new.pay_len = dp_d;
					end
				end
			end else begin
				pos_d = pos_q + 17'd1;
			end
		end

		// a frame end restarts header hunting
		if (emit) begin
			pos_d = 17'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hdr_q       <= 16'd0;
			typ_q       <= 8'd0;
			dp_q        <= 16'd0;
			frame_cnt_q <= 32'd0;
		end else if (accept) begin
			pos_q <= pos_d;
			hdr_q <= hdr_d;
			typ_q <= typ_d;
			dp_q  <= dp_d;
			if (emit) begin
				frame_cnt_q <= frame_cnt_q + 32'd1;
			end
		end
	end

	// output register and skid stage: valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!push) begin
				out_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// output register and skid stage: payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res_new;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_q <= res_new;
			end else begin
				out_q <= res_new;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_kind     = out_q.kind;
	assign frame_status   = out_q.status;
	assign core_length    = out_q.frame_len;
	assign payload_length = out_q.pay_len;
	assign frames_seen    = out_q.seen;

	`ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`ASSERT_IMPL(a_pos_in_frame, clk, arst_n, pos_q >= 17'd3, pos_q <= ({1'b0, hdr_q} + 17'd1))
	`ASSERT_IMPL(a_hdr_nonzero, clk, arst_n, pos_q >= 17'd2, hdr_q != 16'd0)
	`ASSERT_NEXT(a_count_step, clk, arst_n, push, frame_cnt_q == ($past(frame_cnt_q) + 32'd1))

endmodule
`default_nettype wire

>>> tb/sv/length_prefixed_response_deframer_tb.sv
// Testbench for the length-prefixed response deframer: framed byte stimulus and result scoreboard
import lprd_pkg::*;

class frame_scoreboard;
	logic [7:0]  fail_code;
	logic [7:0]  ok_code;
	logic [7:0]  pong_code;
	logic [7:0]  info_code;
	logic [7:0]  keys_code;
	logic [16:0] max_bytes;

	logic [16:0] pos;
	logic [15:0] hdr_len;
	logic [7:0]  type_b;
	logic [15:0] decl_pay;
	logic [31:0] frame_count;

	res_t        awaited_frames[$];
	int unsigned error_count;

	function new();
		fail_code   = 8'd0;
		ok_code     = 8'd1;
		pong_code   = 8'd2;
		info_code   = 8'd3;
		keys_code   = 8'd4;
		max_bytes   = 17'd4096;
		pos         = '0;
		hdr_len     = '0;
		type_b      = '0;
		decl_pay    = '0;
		frame_count = '0;
		error_count = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [16:0] val);
		case (idx)
			REG_FAILURE: fail_code = val[7:0];
			REG_SUCCESS: ok_code = val[7:0];
			REG_PING:    pong_code = val[7:0];
			REG_INFO:    info_code = val[7:0];
			REG_KEYS:    keys_code = val[7:0];
			REG_MAXLEN:  max_bytes = val;
			default: ;
		endcase
	endfunction

	function bit at_boundary();
		return pos == 17'd0;
	endfunction

	function int unsigned pending();
		return awaited_frames.size();
	endfunction

	function void push_frame(logic [2:0] kind, logic [2:0] status, logic [15:0] plen);
		res_t r;
		frame_count = frame_count + 32'd1;
		r.kind      = kind;
		r.status    = status;
		r.frame_len = hdr_len;
		r.pay_len   = plen;
		r.seen      = frame_count;
		awaited_frames.push_back(r);
		pos = '0;
	endfunction

	// Classify a frame longer than one byte once its last byte is in
	function void close_long();
		logic [2:0] kind;
		if (type_b == ok_code)
			kind = KIND_VALUE;
		else if (type_b == pong_code)
			kind = KIND_PONG;
		else if (type_b == info_code)
			kind = KIND_INFO;
		else if (type_b == keys_code)
			kind = KIND_KEYS;
		else begin
			push_frame(KIND_ERROR, ST_UNKNOWN, 16'd0);
			return;
		end
		if (hdr_len < 16'd3)
			push_frame(kind, ST_SHORT, 16'd0);
		else if (decl_pay != hdr_len - 16'd3)
			push_frame(kind, ST_MISMATCH, decl_pay);
		else
			push_frame(kind, ST_GOOD, decl_pay);
	endfunction

	function void track_byte(logic [7:0] b);
		logic [16:0] p;
		p = pos;
		case (p)
			17'd0: begin
				hdr_len  = {b, 8'h00};
				type_b   = '0;
				decl_pay = '0;
				pos      = 17'd1;
			end
			17'd1: begin
				hdr_len[7:0] = b;
				if ({1'b0, hdr_len} + 17'd2 > max_bytes)
					push_frame(KIND_ERROR, ST_LARGE, 16'd0);
				else if (hdr_len == 16'd0)
					push_frame(KIND_ERROR, ST_SHORT, 16'd0);
				else
					pos = 17'd2;
			end
			17'd2: begin
				type_b = b;
				if (hdr_len == 16'd1) begin
					if (b == fail_code)
						push_frame(KIND_ERROR, ST_GOOD, 16'd0);
					else if (b == ok_code)
						push_frame(KIND_OK, ST_GOOD, 16'd0);
					else
						push_frame(KIND_ERROR, ST_UNKNOWN, 16'd0);
				end else begin
					pos = 17'd3;
				end
			end
			default: begin
				if (p == 17'd3)
					decl_pay = {b, 8'h00};
				else if (p == 17'd4)
					decl_pay[7:0] = b;
				if (p >= {1'b0, hdr_len} + 17'd1)
					close_long();
				else
					pos = p + 17'd1;
			end
		endcase
	endfunction

	function void check_frame(logic [2:0] kind, logic [2:0] status, logic [15:0] core,
			logic [15:0] plen, logic [31:0] seen);
		res_t want;
		if (awaited_frames.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("%0t: unexpected result kind %0d status %0d core %0d payload %0d seen %0d",
					$time, kind, status, core, plen, seen);
			return;
		end
		want = awaited_frames.pop_front();
		if (kind !== want.kind || status !== want.status || core !== want.frame_len ||
				plen !== want.pay_len || seen !== want.seen) begin
			error_count++;
			if (error_count <= 10)
				$display("%0t: result mismatch: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
					$time, want.kind, want.status, want.frame_len, want.pay_len, want.seen,
					kind, status, core, plen, seen);
		end
	endfunction
endclass

module length_prefixed_response_deframer_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [16:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  frame_kind;
	logic [2:0]  frame_status;
	logic [15:0] core_length;
	logic [15:0] payload_length;
	logic [31:0] frames_seen;

	frame_scoreboard sb;
	int unsigned     send_gap_pct = 0;
	int unsigned     out_stall_pct = 0;
	int unsigned     bytes_sent = 0;

	// too large, empty, bare failure, bare success, short pong, good value, keys mismatch
	logic [7:0] directed_bytes [0:24] = '{
		8'hFF, 8'hFF,
		8'h00, 8'h00,
		8'h00, 8'h01, 8'h00,
		8'h00, 8'h01, 8'h01,
		8'h00, 8'h02, 8'h02, 8'h5A,
		8'h00, 8'h03, 8'h01, 8'h00, 8'h00,
		8'h00, 8'h04, 8'h04, 8'hFF, 8'h00, 8'hA5
	};

	length_prefixed_response_deframer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_kind(frame_kind),
		.frame_status(frame_status),
		.core_length(core_length),
		.payload_length(payload_length),
		.frames_seen(frames_seen)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_frame(frame_kind, frame_status, core_length, payload_length, frames_seen);
	end

	initial begin
		#2000000;
		$display("[length_prefixed_response_deframer] ERROR");
		$finish;
	end

	function automatic logic [7:0] pick_code();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			2, 3, 4: return 8'($urandom_range(5));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] matched_code();
		case ($urandom_range(3))
			0: return sb.ok_code;
			1: return sb.pong_code;
			2: return sb.info_code;
			default: return sb.keys_code;
		endcase
	endfunction

	function automatic int unsigned payload_size();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 80)
			return $urandom_range(12);
		if (pick < 95)
			return $urandom_range(80, 13);
		return $urandom_range(300, 81);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance with valid still high
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.track_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Header, type and payload length bytes, then filler until the frame closes
	task automatic send_frame(input logic [15:0] len, input logic [7:0] code,
			input logic [15:0] decl);
		logic [39:0] head;
		head = {len, code, decl};
		for (int i = 0; i < 5; i++) begin
			send_byte(head[39 - 8 * i -: 8]);
			if (sb.at_boundary())
				return;
		end
		while (!sb.at_boundary())
			send_byte(8'($urandom));
	endtask

	task automatic send_random_frame();
		int unsigned pick;
		int unsigned len;
		int unsigned lo;
		logic [7:0]  code;
		logic [15:0] decl;
		pick = $urandom_range(99);
		code = matched_code();
		decl = 16'($urandom);
		len = $urandom_range(20, 3);
		if (pick < 40) begin
			len = payload_size() + 3;
			if (sb.max_bytes <= 400 && $urandom_range(9) == 0)
				len = 32'(sb.max_bytes) - 2;
			decl = 16'(len - 3);
		end else if (pick < 50) begin
			len = 1;
			case ($urandom_range(2))
				0: code = sb.fail_code;
				1: code = sb.ok_code;
				default: code = 8'($urandom);
			endcase
		end else if (pick < 57) begin
			len = 2 * $urandom_range(1);
		end else if (pick < 65) begin
			code = 8'($urandom);
		end else if (pick < 75) begin
			// off by one either way, otherwise a random declared length
			if ($urandom_range(1))
				decl = 16'(len - 4 + 2 * $urandom_range(1));
		end else if (pick < 85) begin
			if (sb.max_bytes <= 17'd65536) begin
				lo = 32'(sb.max_bytes) - 1;
				len = $urandom_range(1) ? lo : $urandom_range(65535, lo);
			end
		end else begin
			code = 8'($urandom);
			if (sb.max_bytes <= 1000)
				len = $urandom_range(65535);
			else
				len = $urandom_range(30);
		end
		send_frame(16'(len), code, decl);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic configure(input int ph);
		logic [7:0]  f;
		logic [7:0]  s;
		logic [7:0]  pg;
		logic [7:0]  inf;
		logic [7:0]  k;
		logic [16:0] mx;
		f = pick_code();
		s = pick_code();
		pg = pick_code();
		inf = pick_code();
		k = pick_code();
		case (ph)
			1: mx = 17'd3;
			2: begin
				// shared codes: the match order decides
				f = 8'($urandom_range(2));
				s = 8'($urandom_range(2));
				pg = 8'($urandom_range(2));
				inf = 8'($urandom_range(2));
				k = 8'($urandom_range(2));
				mx = 17'd5;
			end
			3: begin
				f = 8'hFF;
				s = 8'h00;
				pg = 8'h80;
				inf = 8'h7F;
				k = 8'h00;
				mx = 17'd65537;
			end
			4: mx = 17'($urandom_range(400, 6));
			5: mx = 17'd4;
			6: begin
				f = 8'($urandom_range(3));
				s = 8'($urandom_range(3));
				pg = 8'($urandom_range(3));
				mx = 17'd65536;
			end
			default: mx = 17'($urandom_range(200, 20));
		endcase
		write_reg(REG_FAILURE, {9'd0, f});
		write_reg(REG_SUCCESS, {9'd0, s});
		write_reg(REG_PING, {9'd0, pg});
		write_reg(REG_INFO, {9'd0, inf});
		write_reg(REG_KEYS, {9'd0, k});
		write_reg(REG_MAXLEN, mx);
		cfg_we <= 1'b0;
	endtask

	// Hold until every result is out, then for the given number of extra cycles
	task automatic drain(input int extra);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int unsigned phase_start;
		sb = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int ph = 0; ph < 8; ph++) begin
			if (ph != 0) begin
				drain(4);
				configure(ph);
			end
			case (ph % 4)
				0: begin send_gap_pct = 0;  out_stall_pct = 0;  end
				1: begin send_gap_pct = 65; out_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  out_stall_pct = 65; end
				default: begin send_gap_pct = 6; out_stall_pct = 6; end
			endcase
			if (ph == 0)
				foreach (directed_bytes[i])
					send_byte(directed_bytes[i]);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < 240)
				send_random_frame();
			in_valid <= 1'b0;
		end
		drain(8);
		if (sb.error_count == 0)
			$display("[length_prefixed_response_deframer] OK");
		else
			$display("[length_prefixed_response_deframer] ERROR");
		$finish;
	end

endmodule

>>> length_prefixed_response_deframer.f
+incdir+rtl/core
rtl/core/lprd_pkg.sv
rtl/core/length_prefixed_response_deframer.sv
tb/sv/length_prefixed_response_deframer_tb.sv
